### hdl/mtfd_pkg.sv
// mtfd_pkg: constants, types and register codes of the multi-tap fractional delay line
// used by every other file of the block; depends on nothing

package mtfd_pkg;

  localparam int DEPTH     = 8192;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int LEN_W     = 14;
  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 22;
  localparam int FRAC_W    = 8;
  localparam int NUM_TAPS  = 4;
  localparam int TAPS_W    = 3;
  localparam int TAP_IDX_W = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(4410);
  localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(1);

  typedef enum logic [0:0] {
    REG_LENGTH = 1'b0,
    REG_TAPS   = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_PROCESS = 1'b0,
    OP_CLEAR   = 1'b1
  } op_t;

  // effective configuration plus length write strobe
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [TAPS_W-1:0] taps;
    logic              len_wr;
  } cfg_t;

  typedef struct packed {
    logic                 load;
    logic                 addr_en;
    logic                 rd_en;
    logic                 rd_sel;
    logic                 cap_y1;
    logic                 cap_y2;
    logic                 mul_en;
    logic                 out_load;
    logic                 out_last;
    logic [TAP_IDX_W-1:0] tap;
    logic                 wr_sample;
    logic                 wr_clear;
    logic [ADDR_W-1:0]    clr_addr;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

### hdl/mtfd_if.sv
// mtfd_in_if and mtfd_out_if: valid/ready channels for input words and tap results
// depends on mtfd_pkg

interface mtfd_in_if;
  import mtfd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic signed [DELAY_W-1:0]  delay_0;
  logic signed [DELAY_W-1:0]  delay_1;
  logic signed [DELAY_W-1:0]  delay_2;
  logic signed [DELAY_W-1:0]  delay_3;

  modport source (output valid, op, sample_in, delay_0, delay_1, delay_2, delay_3,
                  input ready);
  modport sink (input valid, op, sample_in, delay_0, delay_1, delay_2, delay_3,
                output ready);
endinterface

interface mtfd_out_if;
  import mtfd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [SAMPLE_W-1:0] tap_value;
  logic                       last;

  modport source (output valid, tap_index, tap_value, last, input ready);
  modport sink (input valid, tap_index, tap_value, last, output ready);
endinterface

### hdl/mtfd_cfg.sv
// mtfd_cfg: APB register file for buffer_length and active_taps
// depends on mtfd_pkg; gives the clamped settings to the rest of the block

module mtfd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mtfd_pkg::PADDR_W-1:0]   paddr,
  input  logic [mtfd_pkg::PDATA_W-1:0]   pwdata,
  output logic [mtfd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output mtfd_pkg::cfg_t                 cfg
);
  import mtfd_pkg::*;

  logic [LEN_W-1:0]  buffer_length;
  logic [TAPS_W-1:0] active_taps;
  logic              wr;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= LEN_RESET;
      active_taps   <= TAPS_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_LENGTH: buffer_length <= pwdata[LEN_W-1:0];
        REG_TAPS:   active_taps   <= pwdata[TAPS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LENGTH: prdata = PDATA_W'(buffer_length);
      REG_TAPS:   prdata = PDATA_W'(active_taps);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (buffer_length < LEN_W'(2)) begin
      cfg.len = LEN_W'(2);
    end else if (buffer_length > LEN_W'(DEPTH)) begin
      cfg.len = LEN_W'(DEPTH);
    end else begin
      cfg.len = buffer_length;
    end
    if (active_taps == '0) begin
      cfg.taps = TAPS_W'(1);
    end else if (active_taps > TAPS_W'(NUM_TAPS)) begin
      cfg.taps = TAPS_W'(NUM_TAPS);
    end else begin
      cfg.taps = active_taps;
    end
    cfg.len_wr = wr && (idx == REG_LENGTH);
  end

endmodule

### hdl/mtfd_dpath.sv
// mtfd_dpath: sample store, write pointer, delay clamp, address wrap,
// interpolation multiplier and result register; depends on mtfd_pkg

module mtfd_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  mtfd_pkg::cfg_t                     cfg,
  input  mtfd_pkg::cmd_t                     cmd,
  output mtfd_pkg::sts_t                     sts,
  input  logic signed [mtfd_pkg::SAMPLE_W-1:0] sample_in,
  input  logic signed [mtfd_pkg::DELAY_W-1:0]  delay_0,
  input  logic signed [mtfd_pkg::DELAY_W-1:0]  delay_1,
  input  logic signed [mtfd_pkg::DELAY_W-1:0]  delay_2,
  input  logic signed [mtfd_pkg::DELAY_W-1:0]  delay_3,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mtfd_pkg::TAP_IDX_W-1:0]     out_tap_index,
  output logic signed [mtfd_pkg::SAMPLE_W-1:0] out_tap_value,
  output logic                               out_last
);
  import mtfd_pkg::*;

  localparam int LIM_W  = LEN_W + FRAC_W + 1;
  localparam int SADR_W = ADDR_W + 2;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;
  localparam int SUM_W  = PROD_W - FRAC_W;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [DELAY_W-1:0]  delay_r [NUM_TAPS];
  logic [ADDR_W-1:0]          wp;
  logic [ADDR_W-1:0]          wp_eff;
  logic [ADDR_W-1:0]          addr1, addr2;
  logic [FRAC_W-1:0]          frac_r;
  logic signed [SAMPLE_W-1:0] y1, y2;
  logic signed [PROD_W-1:0]   prod;

  logic signed [DELAY_W-1:0]  d_sel;
  logic signed [LIM_W-1:0]    d_ext, lim;
  logic [ADDR_W-1:0]          ip;
  logic [FRAC_W-1:0]          fr;
  logic signed [SADR_W-1:0]   a1_raw, a1_w, a2_raw, a2_w, len_s;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [SUM_W-1:0]    sum;
  logic                       we;
  logic [ADDR_W-1:0]          waddr, raddr;
  logic signed [SAMPLE_W-1:0] wdata;

  assign wp_eff = ({1'b0, wp} >= cfg.len) ? '0 : wp;

  // delay clamp and read addresses
  always_comb begin
    d_sel = delay_r[cmd.tap];
    d_ext = LIM_W'(d_sel);
    lim   = $signed({1'b0, cfg.len, {FRAC_W{1'b0}}});
    if (d_ext >= lim) begin
      ip = ADDR_W'(cfg.len - LEN_W'(1));
      fr = '0;
    end else if (d_ext < LIM_W'(1 << FRAC_W)) begin
      ip = ADDR_W'(1);
      fr = '0;
    end else begin
      ip = d_sel[FRAC_W +: ADDR_W];
      fr = d_sel[FRAC_W-1:0];
    end
    len_s  = $signed(SADR_W'(cfg.len));
    a1_raw = $signed({2'b00, wp_eff}) - $signed({2'b00, ip});
    a1_w   = (a1_raw < 0) ? a1_raw + len_s : a1_raw;
    a2_raw = a1_w - SADR_W'(1);
    a2_w   = (a2_raw < 0) ? a2_raw + len_s : a2_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (cfg.len_wr) begin
      wp <= '0;
    end else if (cmd.wr_sample) begin
      wp <= ({1'b0, wp_eff} + LEN_W'(1) >= cfg.len) ? '0 : wp_eff + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r   <= sample_in;
      delay_r[0] <= delay_0;
      delay_r[1] <= delay_1;
      delay_r[2] <= delay_2;
      delay_r[3] <= delay_3;
    end
    if (cmd.addr_en) begin
      addr1  <= a1_w[ADDR_W-1:0];
      addr2  <= a2_w[ADDR_W-1:0];
      frac_r <= fr;
    end
    if (cmd.cap_y1) begin
      y1 <= rdata;
    end
    if (cmd.cap_y2) begin
      y2 <= rdata;
    end
    if (cmd.mul_en) begin
      prod <= $signed({1'b0, frac_r}) * diff;
    end
  end

  assign diff = DIFF_W'(y2) - DIFF_W'(y1);

  // sample store
  assign we    = cmd.wr_clear || cmd.wr_sample;
  assign waddr = cmd.wr_clear ? cmd.clr_addr : wp_eff;
  assign wdata = cmd.wr_clear ? '0 : sample_r;
  assign raddr = cmd.rd_sel ? addr2 : addr1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // result register
  assign sum = SUM_W'(y1) + SUM_W'(prod >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_tap_index <= cmd.tap;
      out_tap_value <= sum[SAMPLE_W-1:0];
      out_last      <= cmd.out_last;
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

endmodule

### hdl/mtfd_ctrl.sv
// mtfd_ctrl: sequencer for store clearing, per-tap reads, interpolation and sample write
// depends on mtfd_pkg; drives mtfd_dpath through cmd_t and reads sts_t

module mtfd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  mtfd_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_ready,
  output mtfd_pkg::cmd_t cmd,
  input  mtfd_pkg::sts_t sts
);
  import mtfd_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_RD1,
    S_RD2,
    S_RD3,
    S_MUL,
    S_RES,
    S_WRITE
  } state_t;

  state_t               state;
  logic [ADDR_W-1:0]    cnt;
  logic [TAP_IDX_W-1:0] tap;
  logic                 last_tap;

  assign in_ready = (state == S_IDLE);
  assign last_tap = (TAPS_W'(tap) + TAPS_W'(1) == cfg.taps);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      tap   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            tap <= '0;
            cnt <= '0;
            state <= (op_t'(in_op) == OP_CLEAR) ? S_CLEAR : S_ADDR;
          end
        end
        S_ADDR:  state <= S_RD1;
        S_RD1:   state <= S_RD2;
        S_RD2:   state <= S_RD3;
        S_RD3:   state <= S_MUL;
        S_MUL:   state <= S_RES;
        S_RES: begin
          if (!sts.out_busy) begin
            if (last_tap) begin
              state <= S_WRITE;
            end else begin
              tap   <= tap + TAP_IDX_W'(1);
              state <= S_ADDR;
            end
          end
        end
        S_WRITE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.tap       = tap;
    cmd.clr_addr  = cnt;
    cmd.out_last  = last_tap;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.addr_en   = (state == S_ADDR);
    cmd.rd_en     = (state == S_RD1) || (state == S_RD2);
    cmd.rd_sel    = (state == S_RD2);
    cmd.cap_y1    = (state == S_RD2);
    cmd.cap_y2    = (state == S_RD3);
    cmd.mul_en    = (state == S_MUL);
    cmd.out_load  = (state == S_RES) && !sts.out_busy;
    cmd.wr_sample = (state == S_WRITE);
    cmd.wr_clear  = (state == S_CLEAR);
  end

endmodule

### hdl/multi_tap_fractional_delay_line_unit.sv
// multi_tap_fractional_delay_line_unit: top level of the multi-tap fractional delay line
// depends on mtfd_pkg, mtfd_if, mtfd_cfg, mtfd_ctrl and mtfd_dpath
//
// Each process word reads every active tap from a circular store of 16-bit samples,
// interpolates linearly between the two samples around the clamped Q14.8 delay and
// returns one result per tap in tap order, last marked, before the new sample is written.
// The store has one read port with registered data, so each tap steps through address,
// two reads, capture, multiply and result states before its result is given;
// a stalled result holds the sequencer at that tap. A clear word clears one entry per
// cycle over the whole store and gives no results. After reset the same clearing pass
// runs before the first word is taken; register writes are taken at any time. Writing
// buffer_length moves the write position to 0.

module multi_tap_fractional_delay_line_unit (
  input  logic                          clk,
  input  logic                          rst,
  mtfd_in_if.sink                       item,
  mtfd_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtfd_pkg::PADDR_W-1:0]  paddr,
  input  logic [mtfd_pkg::PDATA_W-1:0]  pwdata,
  output logic [mtfd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import mtfd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  mtfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (item.valid),
    .in_op    (item.op),
    .in_ready (item.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mtfd_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .sample_in     (item.sample_in),
    .delay_0       (item.delay_0),
    .delay_1       (item.delay_1),
    .delay_2       (item.delay_2),
    .delay_3       (item.delay_3),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_tap_index (result.tap_index),
    .out_tap_value (result.tap_value),
    .out_last      (result.last)
  );

endmodule

### sim/mtfd_checker.sv
// mtfd_checker: watches the word and tap result channels and the register port of the
// delay line, predicts every tap result and compares it field by field
// depends on mtfd_pkg and mtfd_if

module mtfd_checker (
  input  logic                         clk,
  input  logic                         rst,
  mtfd_in_if                           item,
  mtfd_out_if                          result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [mtfd_pkg::PADDR_W-1:0] paddr,
  input  logic [mtfd_pkg::PDATA_W-1:0] pwdata,
  output int                           fail_count,
  output int                           pending
);
  import mtfd_pkg::*;

  typedef struct packed {
    logic [TAP_IDX_W-1:0]       idx;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } tap_result_t;

  logic signed [SAMPLE_W-1:0] delay_store [DEPTH];
  logic [ADDR_W-1:0]          wr_pos;
  logic [LEN_W-1:0]           len_reg;
  logic [TAPS_W-1:0]          taps_reg;
  tap_result_t                expected_taps [$];
  int                         errors;

  function automatic int eff_len();
    if (len_reg < 2) return 2;
    if (len_reg > DEPTH) return DEPTH;
    return int'(len_reg);
  endfunction

  function automatic int eff_taps();
    if (taps_reg == 0) return 1;
    if (taps_reg > NUM_TAPS) return NUM_TAPS;
    return int'(taps_reg);
  endfunction

  function automatic int wrap_index(input int a, input int len);
    if (a < 0) a += len;
    if (a >= len) a -= len;
    if (a < 0 || a >= len) a = 0;
    return a;
  endfunction

  task automatic interpolate_taps(input logic signed [SAMPLE_W-1:0] smp,
                                  input logic signed [DELAY_W-1:0] d0,
                                  input logic signed [DELAY_W-1:0] d1,
                                  input logic signed [DELAY_W-1:0] d2,
                                  input logic signed [DELAY_W-1:0] d3);
    int len, taps, wp, d, ip, fr, y1, y2;
    logic signed [DELAY_W-1:0] dly [NUM_TAPS];
    tap_result_t r;
    len = eff_len();
    taps = eff_taps();
    wp = int'(wr_pos);
    if (wp >= len) wp = 0;
    dly[0] = d0;
    dly[1] = d1;
    dly[2] = d2;
    dly[3] = d3;
    for (int j = 0; j < taps; j++) begin
      d = int'(dly[j]);
      // clamp below 1.0 to 1.0, and from len upward to len-1 with zero fraction
      if (d >= (len << FRAC_W)) d = (len - 1) << FRAC_W;
      else if (d < (1 << FRAC_W)) d = 1 << FRAC_W;
      ip = d >>> FRAC_W;
      fr = d & ((1 << FRAC_W) - 1);
      y1 = int'(delay_store[wrap_index(wp - ip, len)]);
      y2 = int'(delay_store[wrap_index(wp - ip - 1, len)]);
      r.idx = TAP_IDX_W'(j);
      r.value = SAMPLE_W'(y1 + ((fr * (y2 - y1)) >>> FRAC_W));
      r.last = (j == taps - 1);
      expected_taps.push_back(r);
    end
    delay_store[wp] = smp;
    wp++;
    if (wp >= len) wp = 0;
    wr_pos = ADDR_W'(wp);
  endtask

  always @(posedge clk) begin
    tap_result_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) delay_store[i] = '0;
      wr_pos = '0;
      len_reg = LEN_RESET;
      taps_reg = TAPS_RESET;
      expected_taps.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_LENGTH) begin
          len_reg = pwdata[LEN_W-1:0];
          wr_pos = '0;
        end else if (paddr[PADDR_W-1:2] == REG_TAPS) begin
          taps_reg = pwdata[TAPS_W-1:0];
        end
      end
      if (result.valid && result.ready) begin
        if (expected_taps.size() == 0) begin
          $error("unexpected tap result: tap_index %0d tap_value %0d last %0d",
                 result.tap_index, result.tap_value, result.last);
          errors++;
        end else begin
          want = expected_taps.pop_front();
          if (result.tap_index !== want.idx) begin
            $error("tap_index expected %0d actual %0d", want.idx, result.tap_index);
            errors++;
          end
          if (result.tap_value !== want.value) begin
            $error("tap_value expected %0d actual %0d", want.value, result.tap_value);
            errors++;
          end
          if (result.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, result.last);
            errors++;
          end
        end
      end
      if (item.valid && item.ready) begin
        if (item.op == OP_CLEAR) begin
          for (int i = 0; i < DEPTH; i++) delay_store[i] = '0;
        end else begin
          interpolate_taps(item.sample_in, item.delay_0, item.delay_1, item.delay_2,
                           item.delay_3);
        end
      end
    end
    fail_count <= errors;
    pending <= expected_taps.size();
  end

endmodule

### sim/tb.sv
// tb: drives sample and clear words and register writes into the delay line under
// varied idling and back pressure, and reports the verdict of mtfd_checker
// depends on mtfd_pkg, mtfd_if, multi_tap_fractional_delay_line_unit and mtfd_checker

module tb;
  import mtfd_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [DELAY_W-1:0] DELAY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic [DELAY_W-1:0] DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic               pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_ticket = 0;
  int                 hold_len = 0;
  int                 hold_seen;
  int                 hold_left;

  mtfd_in_if  in_ch ();
  mtfd_out_if out_ch ();

  multi_tap_fractional_delay_line_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (in_ch),
    .result  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mtfd_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .item       (in_ch),
    .result     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls plus long hold-offs on request
  initial begin
    out_ch.ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(input op_t op, input logic [SAMPLE_W-1:0] smp,
                           input logic [DELAY_W-1:0] d0, input logic [DELAY_W-1:0] d1,
                           input logic [DELAY_W-1:0] d2, input logic [DELAY_W-1:0] d3);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.sample_in <= smp;
    in_ch.delay_0 <= d0;
    in_ch.delay_1 <= d1;
    in_ch.delay_2 <= d2;
    in_ch.delay_3 <= d3;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // a clear word may still be running after the last tap result
  task automatic set_delay_line(input int len, input int taps);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DEPTH + 64) @(posedge clk);
    apb_write(REG_LENGTH, PDATA_W'(len));
    apb_write(REG_TAPS, PDATA_W'(taps));
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(19))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [DELAY_W-1:0] rand_delay(input int len);
    int pick;
    int span;
    pick = $urandom_range(99);
    span = (len < 40) ? len : 40;
    if (pick < 40) return DELAY_W'($urandom_range(span * 256 + 511));
    if (pick < 60) return DELAY_W'($urandom_range(len * 256 + 511));
    if (pick < 80) return DELAY_W'($urandom);
    case ($urandom_range(6))
      0: return '0;
      1: return DELAY_W'(256);
      2: return DELAY_W'(len * 256);
      3: return DELAY_W'(len * 256 - 1);
      4: return DELAY_MAX;
      5: return DELAY_MIN;
      default: return '1;
    endcase
  endfunction

  task automatic random_words(input int count, input int len);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) begin
        send_word(OP_CLEAR, rand_sample(), rand_delay(len), rand_delay(len),
                  rand_delay(len), rand_delay(len));
      end else begin
        send_word(OP_PROCESS, rand_sample(), rand_delay(len), rand_delay(len),
                  rand_delay(len), rand_delay(len));
      end
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_PROCESS;
    in_ch.sample_in <= '0;
    in_ch.delay_0 <= '0;
    in_ch.delay_1 <= '0;
    in_ch.delay_2 <= '0;
    in_ch.delay_3 <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed words on a short line with all taps
    set_delay_line(8, 4);
    send_word(OP_PROCESS, SAMPLE_MAX, DELAY_W'(256), DELAY_W'(256), DELAY_W'(256),
              DELAY_W'(256));
    send_word(OP_PROCESS, SAMPLE_MIN, '0, '1, DELAY_MIN, DELAY_MAX);
    send_word(OP_PROCESS, 16'h1234, DELAY_W'(384), DELAY_W'(513), DELAY_W'(1023),
              DELAY_W'(2047));
    send_word(OP_PROCESS, '1, DELAY_W'(2048), DELAY_W'(1), DELAY_W'(255), DELAY_W'(1024));
    for (int i = 0; i < 9; i++) begin
      send_word(OP_PROCESS, (i % 2) ? SAMPLE_MAX : SAMPLE_MIN,
                DELAY_W'(256 + i * 31), DELAY_W'(512 + (i * 53) % 256),
                DELAY_W'(1920 + i), DELAY_W'(2047 - i));
    end
    send_word(OP_CLEAR, SAMPLE_MAX, DELAY_MAX, DELAY_MAX, DELAY_MAX, DELAY_MAX);
    send_word(OP_PROCESS, 16'h0064, DELAY_W'(256), DELAY_W'(512), DELAY_W'(1024),
              DELAY_W'(1992));
    send_word(OP_PROCESS, 16'hABCD, DELAY_W'(300), DELAY_W'(700), DELAY_W'(1100),
              DELAY_W'(1500));

    set_delay_line(2, 1);
    set_idling(0, 0);
    random_words(30, 2);

    // out of range length and tap count
    set_delay_line(16383, 7);
    set_idling(46, 0);
    random_words(30, DEPTH);

    set_delay_line(0, 0);
    set_idling(0, 46);
    random_words(25, 2);

    // long result hold-off while words keep coming
    set_delay_line(37, 3);
    set_idling(34, 34);
    hold_len = 400;
    hold_ticket++;
    random_words(35, 37);

    set_delay_line(1, 5);
    set_idling(34, 34);
    random_words(25, 2);

    set_delay_line(DEPTH, 2);
    set_idling(0, 46);
    random_words(25, DEPTH);
    in_ch.valid <= 1'b0;
    wait_drained();
    random_words(15, DEPTH);

    set_delay_line(int'(LEN_RESET), 4);
    set_idling(46, 0);
    random_words(30, int'(LEN_RESET));

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (64) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
hdl/mtfd_pkg.sv
hdl/mtfd_if.sv
hdl/mtfd_cfg.sv
hdl/mtfd_dpath.sv
hdl/mtfd_ctrl.sv
hdl/multi_tap_fractional_delay_line_unit.sv
sim/mtfd_checker.sv
sim/tb.sv
